// ===== src/framed_packet_receiver_ack_assert.svh =====
// Assertion macros used by the framed packet receiver reply generator.
`ifndef FRAMED_PACKET_RECEIVER_ACK_ASSERT_SVH
`define FRAMED_PACKET_RECEIVER_ACK_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define FPRA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while in reset.
`define FPRA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/fpra_pkg.sv =====
// Types, constants and helpers for the framed packet receiver.
package fpra_pkg;

  localparam logic [7:0] StartMarkerRst = 8'hAA;
  localparam logic [7:0] ReplyLen       = 8'h01;
  localparam logic [7:0] CodeAck        = 8'h06;
  localparam logic [7:0] CodeNak        = 8'h15;

  localparam logic [1:0] BeatMarker = 2'd0;
  localparam logic [1:0] BeatLen    = 2'd1;
  localparam logic [1:0] BeatCode   = 2'd2;
  localparam logic [1:0] BeatXor    = 2'd3;

  typedef enum logic [1:0] {
    PH_START   = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_CHECK   = 2'd3
  } phase_e;

  // Request from the frame parser to the reply generator.
  typedef struct packed {
    logic       valid;
    logic       ok;
    logic [7:0] marker;
  } reply_req_t;

  function automatic logic [7:0] reply_code(input logic ok);
    return ok ? CodeAck : CodeNak;
  endfunction

  function automatic logic [7:0] reply_byte(input logic [1:0] beat, input logic ok,
                                            input logic [7:0] marker);
    logic [7:0] b;
    case (beat)
      BeatMarker: b = marker;
      BeatLen:    b = ReplyLen;
      BeatCode:   b = reply_code(ok);
      default:    b = marker ^ ReplyLen ^ reply_code(ok);
    endcase
    return b;
  endfunction

endpackage

// ===== src/framed_packet_receiver_ack.sv =====
// Framed packet receiver: start/length/payload/XOR-checksum deframer with ACK/NAK reply.
// Receives one byte word per cycle on s_axis. Frames are start marker, length,
// payload, checksum (XOR of all earlier frame bytes); a zero length goes straight
// to the checksum. The checksum word triggers a four-word reply on m_axis:
// marker, 0x01, 0x06 (ACK) or 0x15 (NAK), and the XOR of those three, with tlast
// on the fourth and tuser = checksum matched on all four. Any non-checksum word is
// taken every cycle; a checksum word is taken once the previous reply has drained
// (its fourth word goes out that same cycle), and the first reply word appears
// in the cycle after the checksum is accepted. The start marker register
// (reset 0xAA) is written through cfg, which is always ready.
module framed_packet_receiver_ack (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] tx_byte
  output logic       m_axis_tlast,
  output logic       m_axis_tuser,   // [0] frame_ok
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);
  import fpra_pkg::*;

  logic [7:0] marker_q;
  logic       accept;
  logic       reply_free;
  reply_req_t req;

  assign cfg_ready_o = 1'b1;
  assign accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q <= StartMarkerRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      marker_q <= cfg_data_i;
    end
  end

  fpra_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .rx_byte_i   (s_axis_tdata),
    .marker_i    (marker_q),
    .reply_free_i(reply_free),
    .ready_o     (s_axis_tready),
    .req_o       (req)
  );

  fpra_reply u_reply (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req),
    .free_o       (reply_free),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

endmodule

// ===== src/fpra_parser.sv =====
// Frame parser: tracks phase, length, payload count and running XOR.
module fpra_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          rx_byte_i,
  input  logic [7:0]          marker_i,
  input  logic                reply_free_i,
  output logic                ready_o,
  output fpra_pkg::reply_req_t req_o
);
  import fpra_pkg::*;

  phase_e     phase_q, phase_d;
  logic [7:0] len_q, len_d;
  logic [7:0] cnt_q, cnt_d;
  logic [7:0] xor_q, xor_d;
  logic [7:0] cnt_inc;

  assign cnt_inc = cnt_q + 8'd1;

  // Next state
  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    xor_d   = xor_q;
    if (accept_i) begin
      unique case (phase_q)
        PH_START: begin
          if (rx_byte_i == marker_i) begin
            xor_d   = rx_byte_i;
            phase_d = PH_LENGTH;
          end
        end
        PH_LENGTH: begin
          len_d   = rx_byte_i;
          xor_d   = xor_q ^ rx_byte_i;
          cnt_d   = '0;
          phase_d = (rx_byte_i == 8'd0) ? PH_CHECK : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          xor_d = xor_q ^ rx_byte_i;
          cnt_d = cnt_inc;
          if (cnt_inc >= len_q) phase_d = PH_CHECK;
        end
        default: phase_d = PH_START;
      endcase
    end
  end

  // Outputs: only a checksum word has to wait for the reply generator
  always_comb begin
    ready_o    = (phase_q != PH_CHECK) || reply_free_i;
    req_o.valid  = accept_i && (phase_q == PH_CHECK);
    req_o.ok     = (rx_byte_i == xor_q);
    req_o.marker = marker_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      len_q   <= '0;
      cnt_q   <= '0;
      xor_q   <= '0;
    end else begin
      phase_q <= phase_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      xor_q   <= xor_d;
    end
  end

endmodule

// ===== src/fpra_reply.sv =====
// Reply generator: emits the four-word ACK/NAK frame from an output register.
module fpra_reply (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fpra_pkg::reply_req_t req_i,
  output logic                 free_o,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,
  output logic                 m_axis_tlast,
  output logic                 m_axis_tuser
);
  import fpra_pkg::*;

  logic       busy_q, busy_d;
  logic [1:0] beat_q, beat_d;
  logic       ok_q, ok_d;
  logic [7:0] marker_q, marker_d;
  logic [7:0] data_q, data_d;
  logic       fire, done;

  assign fire   = busy_q && m_axis_tready;
  assign done   = fire && (beat_q == BeatXor);
  assign free_o = !busy_q || done;

  always_comb begin
    busy_d   = busy_q;
    beat_d   = beat_q;
    ok_d     = ok_q;
    marker_d = marker_q;
    data_d   = data_q;
    if (req_i.valid) begin
      busy_d   = 1'b1;
      beat_d   = BeatMarker;
      ok_d     = req_i.ok;
      marker_d = req_i.marker;
      data_d   = reply_byte(BeatMarker, req_i.ok, req_i.marker);
    end else if (done) begin
      busy_d = 1'b0;
    end else if (fire) begin
      beat_d = beat_q + 2'd1;
      data_d = reply_byte(beat_q + 2'd1, ok_q, marker_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      beat_q <= BeatMarker;
    end else begin
      busy_q <= busy_d;
      beat_q <= beat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q     <= ok_d;
    marker_q <= marker_d;
    data_q   <= data_d;
  end

  assign m_axis_tvalid = busy_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tlast  = (beat_q == BeatXor);
  assign m_axis_tuser  = ok_q;

`include "framed_packet_receiver_ack_assert.svh"

  // a new reply never overwrites one that is still draining
  `FPRA_ASSERT_IMP(a_no_overrun, clk_i, rst_ni, req_i.valid, !busy_q || done)
  `FPRA_ASSERT_NXT(a_beat_step, clk_i, rst_ni, fire && !done && !req_i.valid, busy_q && (beat_q == $past(beat_q) + 2'd1))
  `FPRA_ASSERT_IMP(a_tail_xor, clk_i, rst_ni, busy_q && (beat_q == BeatXor), data_q == (marker_q ^ ReplyLen ^ reply_code(ok_q)))

endmodule
